### rtl/agms_pkg.sv
package agms_pkg;

  localparam int unsigned IdxW     = 4;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned RowOutW  = 16;
  localparam int unsigned CntOutW  = 5;

  typedef enum logic [2:0] {
    CmdAddVertex    = 3'd0,
    CmdRemoveVertex = 3'd1,
    CmdAddEdge      = 3'd2,
    CmdRemoveEdge   = 3'd3,
    CmdReadVertex   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StBad  = 2'd1,
    StFull = 2'd2
  } status_e;

  typedef struct packed {
    logic              add_vtx;
    logic              rem_vtx;
    logic              set_edge;
    logic              clr_edge;
    logic [IdxW-1:0]   a;
    logic [IdxW-1:0]   b;
    logic [ValueW-1:0] value;
  } cell_op_t;

endpackage

### rtl/adjacency_matrix_graph_store.sv
// A request is registered in the command register on acceptance and executed once the output
// register is empty or being read; its result then appears on the master side from the output register.
// A new request is taken only after the command register has handed the last one to the cell row.
// A finished result waits in the output register while the next request is taken.
// Reset clears all rows, the vertex count and both valid flags; values are loaded on add.
module adjacency_matrix_graph_store #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] vertex_value, [35:32] first_index, [39:36] second_index
  input  logic [39:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] vertex_count, [36:5] read_value, [52:37] read_row, [55:53] zero
  output logic [55:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SelW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;

  logic                              cmd_valid_q;
  logic [2:0]                        cmd_q;
  logic [agms_pkg::ValueW-1:0]       val_q;
  logic [agms_pkg::IdxW-1:0]         a_q, b_q;
  logic [CntW-1:0]                   count_q, count_d;
  logic                              m_valid_q;
  agms_pkg::status_e                 status_q, status_d;
  logic [agms_pkg::CntOutW-1:0]      cnt_out_q;
  logic [agms_pkg::ValueW-1:0]       rval_q, rval_d;
  logic [agms_pkg::RowOutW-1:0]      rrow_q, rrow_d;
  logic                              exec;
  logic                              a_ok, b_ok, full;
  logic [SelW-1:0]                   sel;
  logic [31:0]                       cnt_wide;
  logic [63:0]                       row_wide;
  agms_pkg::cell_op_t                op;

  logic [agms_pkg::ValueW-1:0]       cell_value [MAX_VERTICES];
  logic [MAX_VERTICES-1:0]           cell_row   [MAX_VERTICES];

  assign s_axis_tready = !cmd_valid_q;
  assign exec          = cmd_valid_q && (!m_valid_q || m_axis_tready);

  assign a_ok     = int'(a_q) < int'(count_q);
  assign b_ok     = int'(b_q) < int'(count_q);
  assign full     = int'(count_q) >= int'(MAX_VERTICES);
  assign sel      = SelW'(32'(a_q));
  assign row_wide = 64'(cell_row[sel]);

  always_comb begin
    op       = '0;
    op.a     = a_q;
    op.b     = b_q;
    op.value = val_q;
    status_d = agms_pkg::StOk;
    count_d  = count_q;
    rval_d   = '0;
    rrow_d   = '0;
    case (agms_pkg::cmd_e'(cmd_q))
      agms_pkg::CmdAddVertex: begin
        if (full) begin
          status_d = agms_pkg::StFull;
        end else begin
          op.add_vtx = exec;
          count_d    = count_q + CntW'(1);
        end
      end
      agms_pkg::CmdRemoveVertex: begin
        if (!a_ok) begin
          status_d = agms_pkg::StBad;
        end else begin
          op.rem_vtx = exec;
          count_d    = count_q - CntW'(1);
        end
      end
      agms_pkg::CmdAddEdge, agms_pkg::CmdRemoveEdge: begin
        if (!a_ok || !b_ok || a_q == b_q) begin
          status_d = agms_pkg::StBad;
        end else if (agms_pkg::cmd_e'(cmd_q) == agms_pkg::CmdAddEdge) begin
          op.set_edge = exec;
        end else begin
          op.clr_edge = exec;
        end
      end
      agms_pkg::CmdReadVertex: begin
        if (!a_ok) begin
          status_d = agms_pkg::StBad;
        end else begin
          rval_d = cell_value[sel];
          rrow_d = row_wide[agms_pkg::RowOutW-1:0];
        end
      end
      default: status_d = agms_pkg::StBad;
    endcase
  end

  assign cnt_wide = 32'(count_d);

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic [agms_pkg::ValueW-1:0] nxt_value;
    logic [MAX_VERTICES-1:0]     nxt_row;
    if (k + 1 < MAX_VERTICES) begin : g_mid
      assign nxt_value = cell_value[k+1];
      assign nxt_row   = cell_row[k+1];
    end else begin : g_end
      assign nxt_value = '0;
      assign nxt_row   = '0;
    end
    agms_cell #(
      .MAX_VERTICES(MAX_VERTICES),
      .IDX         (k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .count_i     (count_q),
      .next_value_i(nxt_value),
      .next_row_i  (nxt_row),
      .value_o     (cell_value[k]),
      .row_o       (cell_row[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      m_valid_q   <= 1'b0;
      count_q     <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        cmd_valid_q <= 1'b1;
      end else if (exec) begin
        cmd_valid_q <= 1'b0;
      end
      if (exec) begin
        m_valid_q <= 1'b1;
        count_q   <= count_d;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser;
      val_q <= s_axis_tdata[31:0];
      a_q   <= s_axis_tdata[35:32];
      b_q   <= s_axis_tdata[39:36];
    end
    if (exec) begin
      status_q  <= status_d;
      cnt_out_q <= cnt_wide[agms_pkg::CntOutW-1:0];
      rval_q    <= rval_d;
      rrow_q    <= rrow_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, rrow_q, rval_q, cnt_out_q};

endmodule

### rtl/agms_cell.sv
module agms_cell #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned IDX          = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  agms_pkg::cell_op_t                  op_i,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]   count_i,
  input  logic [agms_pkg::ValueW-1:0]         next_value_i,
  input  logic [MAX_VERTICES-1:0]             next_row_i,
  output logic [agms_pkg::ValueW-1:0]         value_o,
  output logic [MAX_VERTICES-1:0]             row_o
);

  localparam logic [MAX_VERTICES-1:0] One = MAX_VERTICES'(1);

  logic [agms_pkg::ValueW-1:0] value_q, value_d;
  logic [MAX_VERTICES-1:0]     row_q, row_d;
  int                          n, ia, ib;

  function automatic logic [MAX_VERTICES-1:0] drop_bit(
    input logic [MAX_VERTICES-1:0] row,
    input logic [agms_pkg::IdxW-1:0] k
  );
    logic [MAX_VERTICES-1:0] below;
    below = (One << k) - One;
    return (row & below) | (((row >> k) >> 1) << k);
  endfunction

  always_comb begin
    n       = int'(count_i);
    ia      = int'(op_i.a);
    ib      = int'(op_i.b);
    value_d = value_q;
    row_d   = row_q;
    if (op_i.add_vtx) begin
      if (int'(IDX) == n) begin
        value_d = op_i.value;
        row_d   = '0;
      end else if (int'(IDX) < n) begin
        row_d = row_q & ~(One << count_i);
      end
    end
    if (op_i.rem_vtx) begin
      if (int'(IDX) >= ia && int'(IDX) + 1 < n) begin
        value_d = next_value_i;
        row_d   = drop_bit(next_row_i, op_i.a);
      end else if (int'(IDX) + 1 == n) begin
        value_d = '0;
        row_d   = '0;
      end else if (int'(IDX) < ia) begin
        row_d = drop_bit(row_q, op_i.a);
      end
    end
    if (op_i.set_edge) begin
      if (int'(IDX) == ia) row_d = row_q | (One << op_i.b);
      if (int'(IDX) == ib) row_d = row_q | (One << op_i.a);
    end
    if (op_i.clr_edge) begin
      if (int'(IDX) == ia) row_d = row_q & ~(One << op_i.b);
      if (int'(IDX) == ib) row_d = row_q & ~(One << op_i.a);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign row_o   = row_q;

endmodule
